FILE: src/hcm_pkg.sv
// Shared types, constants and symbol mapping for the mod-37 Hill cipher encryptor.
// No dependencies; hcm_mac and the top level refer to it by scoped names.
package hcm_pkg;

    localparam int MAX_BLOCK   = 4;
    localparam int SYM_W       = 6;
    localparam int KEY_W       = 6;
    localparam int ROW_W       = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 5;
    localparam int PROD_W      = 11;   // reduced key (<37) times symbol (<37)
    localparam int SCALED_W    = 20;   // product times reciprocal
    localparam int RECIP_MUL   = 443;  // ceil(2^14 / 37), exact for values below 1369
    localparam int RECIP_SHIFT = 14;

    localparam logic [SYM_W-1:0] ALPHA_MOD  = 6'd37;
    localparam logic [SYM_W-1:0] PAD_SYMBOL = 6'd36;
    localparam logic [SYM_W-1:0] DIGIT_BASE = 6'd26;

    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_Z     = 8'h5A;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // register indexes on the configuration port
    localparam logic [2:0] REG_BLOCK_SIZE = 3'd0;
    localparam logic [2:0] REG_KEY_ROW_0  = 3'd1;
    localparam logic [2:0] REG_KEY_ROW_1  = 3'd2;
    localparam logic [2:0] REG_KEY_ROW_2  = 3'd3;
    localparam logic [2:0] REG_KEY_ROW_3  = 3'd4;

    typedef logic [SYM_W-1:0] t_sym;
    typedef logic [MAX_BLOCK-1:0][KEY_W-1:0] t_key_row;

    typedef struct packed {
        logic             valid;
        logic             first;   // first term of a row sum
        logic             last;    // last term of a row sum
        logic [ROW_W-1:0] row;
    } t_mac_ctl;

    typedef struct packed {
        logic             valid;
        logic [ROW_W-1:0] row;
        t_sym             sym;
    } t_mac_res;

    function automatic t_sym sym_of_char(input logic [7:0] c);
        t_sym s;
        s = '0;
        if (c >= CHAR_A && c <= CHAR_Z) begin
            s = SYM_W'(c - CHAR_A);
        end else if (c >= CHAR_0 && c <= CHAR_9) begin
            s = DIGIT_BASE + SYM_W'(c - CHAR_0);
        end else if (c == CHAR_SPACE) begin
            s = PAD_SYMBOL;
        end
        return s;
    endfunction

    function automatic logic [7:0] char_of_sym(input t_sym s);
        logic [7:0] c;
        if (s < DIGIT_BASE) begin
            c = CHAR_A + 8'(s);
        end else if (s < PAD_SYMBOL) begin
            c = CHAR_0 + 8'(s - DIGIT_BASE);
        end else begin
            c = CHAR_SPACE;
        end
        return c;
    endfunction

endpackage

FILE: src/hcm_if.sv
// Valid/ready channel interfaces for plaintext input and ciphertext output.
// No dependencies.
interface hcm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       message_end;

    modport source (output valid, output char_code, output message_end, input ready);
    modport sink   (input valid, input char_code, input message_end, output ready);
endinterface

interface hcm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] cipher_char;
    logic       block_last;
    logic       message_last;

    modport source (output valid, output cipher_char, output block_last,
                    output message_last, input ready);
    modport sink   (input valid, input cipher_char, input block_last,
                    input message_last, output ready);
endinterface

FILE: src/hcm_mac.sv
// Shared multiply-accumulate modulo 37, three pipeline stages.
// Depends on hcm_pkg.
module hcm_mac (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hcm_pkg::t_mac_ctl i_ctl,
    input  logic [hcm_pkg::KEY_W-1:0] i_key,
    input  hcm_pkg::t_sym     i_sym,
    output hcm_pkg::t_mac_res o_res
);

    localparam int SYM_W_P1 = hcm_pkg::SYM_W + 1;

    // stage 1: fold key into 0..36, multiply
    logic [hcm_pkg::KEY_W-1:0]  w_key_red;
    logic [hcm_pkg::PROD_W-1:0] n_s1_prod;
    hcm_pkg::t_mac_ctl          r_s1_ctl;
    logic [hcm_pkg::PROD_W-1:0] r_s1_prod;

    // stage 2: product mod 37 by reciprocal
    logic [hcm_pkg::SCALED_W-1:0] w_scaled;
    hcm_pkg::t_sym                w_quot;
    logic [hcm_pkg::PROD_W-1:0]   w_quot37;
    hcm_pkg::t_sym                n_s2_mod;
    hcm_pkg::t_mac_ctl            r_s2_ctl;
    hcm_pkg::t_sym                r_s2_mod;

    // stage 3: accumulate with one conditional subtract
    hcm_pkg::t_sym       w_base;
    logic [SYM_W_P1-1:0] w_sum;
    hcm_pkg::t_sym       n_acc;
    hcm_pkg::t_sym       r_acc;
    logic                r_res_valid;
    logic [hcm_pkg::ROW_W-1:0] r_res_row;

    assign w_key_red = (i_key >= hcm_pkg::ALPHA_MOD) ? (i_key - hcm_pkg::ALPHA_MOD) : i_key;
    assign n_s1_prod = hcm_pkg::PROD_W'(w_key_red) * hcm_pkg::PROD_W'(i_sym);

    assign w_scaled = hcm_pkg::SCALED_W'(r_s1_prod)
                    * hcm_pkg::SCALED_W'(hcm_pkg::RECIP_MUL);
    assign w_quot   = w_scaled[hcm_pkg::SCALED_W-1:hcm_pkg::RECIP_SHIFT];
    // 37*q as shifts and adds
    assign w_quot37 = hcm_pkg::PROD_W'({w_quot, 5'b0})
                    + hcm_pkg::PROD_W'({w_quot, 2'b0})
                    + hcm_pkg::PROD_W'(w_quot);
    assign n_s2_mod = hcm_pkg::SYM_W'(r_s1_prod - w_quot37);

    assign w_base = r_s2_ctl.first ? '0 : r_acc;
    assign w_sum  = SYM_W_P1'(w_base) + SYM_W_P1'(r_s2_mod);
    assign n_acc  = (w_sum >= SYM_W_P1'(hcm_pkg::ALPHA_MOD))
                  ? hcm_pkg::SYM_W'(w_sum - SYM_W_P1'(hcm_pkg::ALPHA_MOD))
                  : hcm_pkg::SYM_W'(w_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl    <= '0;
            r_s2_ctl    <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_s1_ctl    <= i_ctl;
            r_s2_ctl    <= r_s1_ctl;
            r_res_valid <= r_s2_ctl.valid && r_s2_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_prod <= n_s1_prod;
        r_s2_mod  <= n_s2_mod;
        if (r_s2_ctl.valid) begin
            r_acc     <= n_acc;
            r_res_row <= r_s2_ctl.row;
        end
    end

    assign o_res.valid = r_res_valid;
    assign o_res.row   = r_res_row;
    assign o_res.sym   = r_acc;

endmodule

FILE: src/hill_cipher_mod37_encrypt_top.sv
// Top level of the mod-37 Hill cipher encryptor: APB registers, block buffer,
// sequencer and ciphertext output. Depends on hcm_pkg, hcm_if and hcm_mac.
//
// Usage:
//   i_in  : one plaintext byte per transaction (char_code, message_end).
//   o_out : one ciphertext byte per transaction, block_last on the last byte
//           of a block, message_last on the last byte of the message.
//   APB   : block_size at 0x00, key rows 0..3 at 0x04..0x10. Write only while
//           idle. pready is tied high.
// Flow, n = effective block size (1..4):
//   - Each input byte that does not close a block is taken; ready stays high.
//   - A closing byte starts the shared MAC, which is issued the n*n key*symbol
//     terms in turn through its pipeline, then n output bytes follow at one
//     byte per cycle while the sink is ready.
//   - The single multiply-accumulate unit computes every term of a block.
// Input ready is low from the closing byte until the last byte of the block
// has been taken. A stalled sink holds the current output byte steady.
// Reset: block_size = 1, key rows = 0, partial block discarded, no output.
module hill_cipher_mod37_encrypt_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    hcm_in_if.sink                         i_in,
    hcm_out_if.source                      o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hcm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [hcm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [hcm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);

    localparam logic [1:0] S_IDLE  = 2'd0;  // collecting input bytes
    localparam logic [1:0] S_CALC  = 2'd1;  // issuing key*symbol terms
    localparam logic [1:0] S_DRAIN = 2'd2;  // waiting on MAC pipeline
    localparam logic [1:0] S_EMIT  = 2'd3;  // handing out ciphertext

    // configuration
    logic [2:0]        r_block_size;
    hcm_pkg::t_key_row r_key [hcm_pkg::MAX_BLOCK];
    logic [2:0]        w_reg_idx;
    logic              w_cfg_wr;

    // datapath and control
    logic [1:0]    r_state;
    logic [1:0]    r_fill;
    hcm_pkg::t_sym r_buf [hcm_pkg::MAX_BLOCK];
    hcm_pkg::t_sym r_res [hcm_pkg::MAX_BLOCK];
    logic          r_msg_end;
    logic [hcm_pkg::ROW_W-1:0] r_i;
    logic [hcm_pkg::ROW_W-1:0] r_j;
    logic [hcm_pkg::ROW_W-1:0] r_eidx;

    logic [2:0]    w_n;
    logic [hcm_pkg::ROW_W-1:0] w_nm1;
    logic          w_accept;
    logic          w_done;
    hcm_pkg::t_sym w_sym;
    hcm_pkg::t_key_row w_key_row;

    hcm_pkg::t_mac_ctl w_mac_ctl;
    hcm_pkg::t_mac_res w_mac_res;

    // ---------------- APB register file ----------------
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[4:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= 3'd1;
            for (int k = 0; k < hcm_pkg::MAX_BLOCK; k++) begin
                r_key[k] <= '0;
            end
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                hcm_pkg::REG_BLOCK_SIZE: r_block_size <= pwdata[2:0];
                hcm_pkg::REG_KEY_ROW_0:  r_key[0]     <= pwdata[23:0];
                hcm_pkg::REG_KEY_ROW_1:  r_key[1]     <= pwdata[23:0];
                hcm_pkg::REG_KEY_ROW_2:  r_key[2]     <= pwdata[23:0];
                hcm_pkg::REG_KEY_ROW_3:  r_key[3]     <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            hcm_pkg::REG_BLOCK_SIZE: prdata = {29'b0, r_block_size};
            hcm_pkg::REG_KEY_ROW_0:  prdata = {8'b0, r_key[0]};
            hcm_pkg::REG_KEY_ROW_1:  prdata = {8'b0, r_key[1]};
            hcm_pkg::REG_KEY_ROW_2:  prdata = {8'b0, r_key[2]};
            hcm_pkg::REG_KEY_ROW_3:  prdata = {8'b0, r_key[3]};
            default:                 prdata = '0;
        endcase
    end

    // effective block size: 0 acts as 1, above 4 clamps to 4
    always_comb begin
        if (r_block_size == 3'd0) begin
            w_n = 3'd1;
        end else if (r_block_size > 3'(hcm_pkg::MAX_BLOCK)) begin
            w_n = 3'(hcm_pkg::MAX_BLOCK);
        end else begin
            w_n = r_block_size;
        end
    end
    assign w_nm1 = hcm_pkg::ROW_W'(w_n - 3'd1);

    // ---------------- input side ----------------
    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_sym      = hcm_pkg::sym_of_char(i_in.char_code);
    // block closes when full or on message end; a lowered block size closes
    // it early and the new symbol falls outside the block
    assign w_done     = !((3'({1'b0, r_fill}) + 3'd1) < w_n) || i_in.message_end;

    // buffer: new symbol at the fill slot, pad the rest of a closing block
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int k = 0; k < hcm_pkg::MAX_BLOCK; k++) begin
                if (2'(k) == r_fill) begin
                    r_buf[k] <= w_sym;
                end else if (w_done && 3'(k) > 3'({1'b0, r_fill}) && 3'(k) < w_n) begin
                    r_buf[k] <= hcm_pkg::PAD_SYMBOL;
                end
            end
        end
    end

    // ---------------- shared MAC ----------------
    assign w_key_row       = r_key[r_i];
    assign w_mac_ctl.valid = (r_state == S_CALC);
    assign w_mac_ctl.first = (r_j == '0);
    assign w_mac_ctl.last  = (r_j == w_nm1);
    assign w_mac_ctl.row   = r_i;

    hcm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_key   (w_key_row[r_j]),
        .i_sym   (r_buf[r_j]),
        .o_res   (w_mac_res)
    );

    always_ff @(posedge i_clk) begin
        if (w_mac_res.valid) begin
            r_res[w_mac_res.row] <= w_mac_res.sym;
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_msg_end <= 1'b0;
            r_i       <= '0;
            r_j       <= '0;
            r_eidx    <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (w_done) begin
                            r_fill    <= '0;
                            r_msg_end <= i_in.message_end;
                            r_i       <= '0;
                            r_j       <= '0;
                            r_state   <= S_CALC;
                        end else begin
                            r_fill <= r_fill + 2'd1;
                        end
                    end
                end
                S_CALC: begin
                    if (r_j == w_nm1) begin
                        r_j <= '0;
                        if (r_i == w_nm1) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_i <= r_i + 2'd1;
                        end
                    end else begin
                        r_j <= r_j + 2'd1;
                    end
                end
                S_DRAIN: begin
                    // last row's sum is the last to leave the pipeline
                    if (w_mac_res.valid && w_mac_res.row == w_nm1) begin
                        r_eidx  <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (o_out.ready) begin
                        if (r_eidx == w_nm1) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_eidx <= r_eidx + 2'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ---------------- output side ----------------
    assign o_out.valid        = (r_state == S_EMIT);
    assign o_out.cipher_char  = hcm_pkg::char_of_sym(r_res[r_eidx]);
    assign o_out.block_last   = (r_eidx == w_nm1);
    assign o_out.message_last = (r_eidx == w_nm1) && r_msg_end;

    // ---------------- assertions ----------------
    a_close_starts_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_done) |=> (r_state == S_CALC))
        else $error("closing transaction did not start the MAC sequence");

    a_res_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mac_res.valid |-> (r_state == S_CALC || r_state == S_DRAIN))
        else $error("MAC result outside of a block computation");

    a_res_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mac_res.valid |-> (w_mac_res.row <= w_nm1))
        else $error("MAC result row beyond block size");

    a_emit_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_eidx <= w_nm1))
        else $error("output index beyond block size");

    a_res_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mac_res.valid |-> (w_mac_res.sym < hcm_pkg::ALPHA_MOD))
        else $error("MAC result not reduced modulo 37");

endmodule
